### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the deque RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// clocked check that also holds while reset is applied
`define ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif

`endif

### rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Sizes, codes and the command/status bundles of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = $clog2(2 * DEPTH);

	localparam int ACT_W = 3;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int OCC_W = 5;

	localparam int IN_TDATA_W  = ((ACT_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_USED_W  = ST_W + VAL_W + OCC_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = ACT_W'(0);
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = ACT_W'(1);
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = ACT_W'(2);
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = ACT_W'(3);
	localparam logic [ACT_W-1:0] ACT_LIST_FWD   = ACT_W'(4);
	localparam logic [ACT_W-1:0] ACT_LIST_BWD   = ACT_W'(5);

	localparam logic [ST_W-1:0] STAT_OK    = ST_W'(0);
	localparam logic [ST_W-1:0] STAT_EMPTY = ST_W'(1);
	localparam logic [ST_W-1:0] STAT_FULL  = ST_W'(2);

	typedef enum logic [1:0] {
		OUT_OK_NONE,
		OUT_OK_DATA,
		OUT_EMPTY,
		OUT_FULL
	} dq_out_kind_t;

	typedef struct packed {
		logic         push_front;
		logic         push_back;
		logic         pop_front;
		logic         pop_back;
		logic         list_start;
		logic         list_dir;   // 1: back to front
		logic         list_rd;
		logic         list_next;
		logic         out_ld;
		logic         out_last;
		dq_out_kind_t out_kind;
	} dq_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             empty;
		logic             full;
		logic             out_free;
		logic             list_last;
	} dq_stat_t;

	// fold a sum below 2*DEPTH back onto the ring
	function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] t;
		t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return t[PTR_W-1:0];
	endfunction

endpackage

### rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values on stream ports.
// ----------------------------------------------------------------------------
// Holds up to DEPTH (16) entries in a ring RAM with a front pointer and a
// count. A push, or any action that returns a status only (push when full,
// pop or list when empty), loads its result beat straight from the idle
// state, and the next beat is accepted once the result register is free. A
// pop passes through the pop state because the entry comes out of the RAM's
// registered read port. A list walks the entries in read and output states,
// reading each entry from the RAM, then emitting it, one result beat per
// entry with tlast on the final one. Unused action codes are taken and dropped.
// Output back-pressure stalls each action until the output register is free.
module double_ended_queue_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dq_pkg::IN_TDATA_W-1:0]      s_tdata,   // action[2:0], value[34:3], zero pad
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dq_pkg::OUT_TDATA_W-1:0]     m_tdata,   // status[1:0], value_res[33:2], occupancy[38:34], zero pad
	output logic                               m_tlast    // last_item
);
	import dq_pkg::*;

	dq_cmd_t  cmd;
	dq_stat_t st;

	dq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	dq_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.st      (st),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

### rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// Deque datapath: front pointer, count, list index, entry RAM, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [dq_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  dq_pkg::dq_cmd_t                    cmd,
	output dq_pkg::dq_stat_t                   st,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dq_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                               m_tlast
);
	import dq_pkg::*;

	logic [ACT_W-1:0] action;
	logic [VAL_W-1:0] in_value;

	logic [PTR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [PTR_W-1:0] idx_q;
	logic             dir_q;

	logic [SUM_W-1:0] front_ext, count_ext, idx_ext;
	logic [PTR_W-1:0] front_m1, front_p1, tail_pos, back_pos, list_pos;

	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic             out_vld_q;
	logic [ST_W-1:0]  out_st_q;
	logic [VAL_W-1:0] out_val_q;
	logic [OCC_W-1:0] out_occ_q;
	logic             out_last_q;

	assign action   = s_tdata[ACT_W-1:0];
	assign in_value = s_tdata[ACT_W+VAL_W-1:ACT_W];

	assign front_ext = SUM_W'(front_q);
	assign count_ext = SUM_W'(count_q);
	assign idx_ext   = SUM_W'(idx_q);

	assign front_m1 = (front_q == '0) ? PTR_W'(DEPTH - 1) : (front_q - 1'b1);
	assign front_p1 = ring_wrap(front_ext + 1'b1);
	assign tail_pos = ring_wrap(front_ext + count_ext);
	assign back_pos = ring_wrap(front_ext + count_ext - 1'b1);
	assign list_pos = dir_q ? ring_wrap(front_ext + count_ext - 1'b1 - idx_ext)
	                        : ring_wrap(front_ext + idx_ext);

	assign ram_we    = cmd.push_front | cmd.push_back;
	assign ram_waddr = cmd.push_front ? front_m1 : tail_pos;
	assign ram_re    = cmd.pop_front | cmd.pop_back | cmd.list_rd;

	always_comb begin
		ram_raddr = list_pos;
		if (cmd.pop_front) begin
			ram_raddr = front_q;
		end else if (cmd.pop_back) begin
			ram_raddr = back_pos;
		end
	end

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		if (cmd.push_front) begin
			front_d = front_m1;
			count_d = count_q + 1'b1;
		end else if (cmd.push_back) begin
			count_d = count_q + 1'b1;
		end else if (cmd.pop_front) begin
			front_d = front_p1;
			count_d = count_q - 1'b1;
		end else if (cmd.pop_back) begin
			count_d = count_q - 1'b1;
		end
	end

	dq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			dir_q   <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.list_start) begin
				idx_q <= '0;
				dir_q <= cmd.list_dir;
			end else if (cmd.list_next) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// result register; a new beat loads only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_last_q <= cmd.out_last;
			out_occ_q  <= OCC_W'(count_d);
			case (cmd.out_kind)
				OUT_OK_DATA: begin
					out_st_q  <= STAT_OK;
					out_val_q <= ram_rdata;
				end
				OUT_EMPTY: begin
					out_st_q  <= STAT_EMPTY;
					out_val_q <= '0;
				end
				OUT_FULL: begin
					out_st_q  <= STAT_FULL;
					out_val_q <= '0;
				end
				default: begin
					out_st_q  <= STAT_OK;
					out_val_q <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_occ_q, out_val_q, out_st_q};

	assign st.action    = action;
	assign st.empty     = (count_q == '0);
	assign st.full      = (count_q == CNT_W'(DEPTH));
	assign st.out_free  = !out_vld_q || m_tready;
	assign st.list_last = ((CNT_W'(idx_q) + 1'b1) == count_q);

	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`ASSERT_CLK(a_push_count, ram_we |=> (count_q == $past(count_q) + 1'b1), "count not grown")
	`ASSERT_CLK(a_pop_front, cmd.pop_front |=> (front_q == $past(front_p1)), "front stuck")

endmodule

### rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Deque controller: decodes the action and sequences pops and list walks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  dq_pkg::dq_stat_t st,
	output dq_pkg::dq_cmd_t  cmd
);
	import dq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_LRD  = 4'b0100,
		S_LOUT = 4'b1000
	} dq_state_t;

	dq_state_t state_q, state_d;
	logic      take;

	assign s_tready = (state_q == S_IDLE) && st.out_free;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.out_kind = OUT_OK_NONE;
		cmd.out_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (st.action)
						ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
							cmd.out_ld = 1'b1;
							if (st.full) begin
								cmd.out_kind = OUT_FULL;
							end else begin
								cmd.push_front = (st.action == ACT_PUSH_FRONT);
								cmd.push_back  = (st.action == ACT_PUSH_BACK);
							end
						end
						ACT_POP_FRONT, ACT_POP_BACK: begin
							if (st.empty) begin
								cmd.out_ld   = 1'b1;
								cmd.out_kind = OUT_EMPTY;
							end else begin
								cmd.pop_front = (st.action == ACT_POP_FRONT);
								cmd.pop_back  = (st.action == ACT_POP_BACK);
								state_d       = S_POP;
							end
						end
						ACT_LIST_FWD, ACT_LIST_BWD: begin
							if (st.empty) begin
								cmd.out_ld   = 1'b1;
								cmd.out_kind = OUT_EMPTY;
							end else begin
								cmd.list_start = 1'b1;
								cmd.list_dir   = (st.action == ACT_LIST_BWD);
								state_d        = S_LRD;
							end
						end
						default: begin
							// unused codes are swallowed without a result
						end
					endcase
				end
			end
			S_POP: begin
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_OK_DATA;
					state_d      = S_IDLE;
				end
			end
			S_LRD: begin
				cmd.list_rd = 1'b1;
				state_d     = S_LOUT;
			end
			S_LOUT: begin
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_OK_DATA;
					cmd.out_last = st.list_last;
					if (st.list_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
						state_d       = S_LRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_CLK(a_load_free, cmd.out_ld |-> st.out_free, "result loaded over a pending beat")
	`ASSERT_CLK(a_push_room, (cmd.push_front || cmd.push_back) |-> !st.full, "push issued on full queue")
	`ASSERT_CLK(a_pop_done, ((state_q == S_POP) && st.out_free) |=> (state_q == S_IDLE), "pop did not return to idle")

endmodule

### sim/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A command list (directed corner cases, then random fill/drain/mixed bursts)
// is streamed into the slave port with random gaps. Every accepted command
// runs through a ring-buffer predictor that queues the result beats it owes;
// each result beat on the master port is checked field by field against the
// oldest owed beat. Both sides pause at random, except for a quiet window.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
	import dq_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_WAIT  = 64;
	localparam int RAND_CMDS   = 135;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [VAL_W-1:0] val;
	} deque_cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] value;
		logic             last;
		logic [OCC_W-1:0] occ;
	} deque_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	deque_cmd_t    cmd_backlog[$];
	deque_result_t owed_results[$];

	// predictor state
	logic [VAL_W-1:0] ring_mem [DEPTH];
	int               head_idx = 0;
	int               held = 0;

	int  errors = 0;
	int  cycles = 0;
	int  beats_in = 0;
	int  beats_out = 0;
	int  n_push = 0, n_pop = 0, n_list = 0, n_unused = 0;
	int  n_full = 0, n_empty = 0, max_held = 0;
	bit  steady;

	// no idling on either side through this stretch of commands
	assign steady = (beats_in >= 100) && (beats_in < 150);

	double_ended_queue_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				owed_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s", $time, msg);
	endtask

	function automatic void owe(input logic [ST_W-1:0] st, input logic [VAL_W-1:0] v,
			input logic lst);
		deque_result_t r;
		r.status = st;
		r.value  = v;
		r.last   = lst;
		r.occ    = OCC_W'(held);
		owed_results.push_back(r);
	endfunction

	// one accepted command through the ring model
	function automatic void deque_step(input logic [ACT_W-1:0] act,
			input logic [VAL_W-1:0] v);
		int pos;
		logic [VAL_W-1:0] got;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				n_push++;
				if (held >= DEPTH) begin
					n_full++;
					owe(STAT_FULL, '0, 1'b1);
				end else begin
					if (act == ACT_PUSH_FRONT) begin
						head_idx = (head_idx + DEPTH - 1) % DEPTH;
						pos = head_idx;
					end else begin
						pos = (head_idx + held) % DEPTH;
					end
					ring_mem[pos] = v;
					held++;
					if (held > max_held)
						max_held = held;
					owe(STAT_OK, '0, 1'b1);
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				n_pop++;
				if (held == 0) begin
					n_empty++;
					owe(STAT_EMPTY, '0, 1'b1);
				end else begin
					if (act == ACT_POP_FRONT) begin
						got = ring_mem[head_idx];
						head_idx = (head_idx + 1) % DEPTH;
					end else begin
						got = ring_mem[(head_idx + held - 1) % DEPTH];
					end
					held--;
					owe(STAT_OK, got, 1'b1);
				end
			end
			ACT_LIST_FWD, ACT_LIST_BWD: begin
				n_list++;
				if (held == 0) begin
					n_empty++;
					owe(STAT_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < held; i++) begin
						if (act == ACT_LIST_FWD)
							pos = (head_idx + i) % DEPTH;
						else
							pos = (head_idx + held - 1 - i) % DEPTH;
						owe(STAT_OK, ring_mem[pos], i == held - 1);
					end
				end
			end
			default: n_unused++;
		endcase
	endfunction

	task automatic check_beat();
		deque_result_t want;
		logic [ST_W-1:0]  got_st;
		logic [VAL_W-1:0] got_val;
		logic [OCC_W-1:0] got_occ;
		got_st  = m_tdata[ST_W-1:0];
		got_val = m_tdata[ST_W +: VAL_W];
		got_occ = m_tdata[ST_W + VAL_W +: OCC_W];
		beats_out++;
		if (owed_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result beat: status %0d value %h occ %0d",
				got_st, got_val, got_occ));
		end else begin
			want = owed_results.pop_front();
			if (got_st !== want.status)
				flag_mismatch($sformatf("beat %0d status: got %0d want %0d",
					beats_out, got_st, want.status));
			if (got_val !== want.value)
				flag_mismatch($sformatf("beat %0d value: got %h want %h",
					beats_out, got_val, want.value));
			if (m_tlast !== want.last)
				flag_mismatch($sformatf("beat %0d tlast: got %b want %b",
					beats_out, m_tlast, want.last));
			if (got_occ !== want.occ)
				flag_mismatch($sformatf("beat %0d occupancy: got %0d want %0d",
					beats_out, got_occ, want.occ));
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= 22)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= IN_TDATA_W'({cmd_backlog[0].val, cmd_backlog[0].act});
				cmd_backlog.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: commands are modeled before result beats of the same edge are checked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				beats_in++;
				deque_step(s_tdata[ACT_W-1:0], s_tdata[ACT_W +: VAL_W]);
			end
			if (m_tvalid && m_tready)
				check_beat();
			m_tready <= steady || ($urandom_range(0, 99) >= 22);
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	int planned = 0;

	function automatic void add_cmd(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] v);
		deque_cmd_t c;
		c.act = act;
		c.val = v;
		cmd_backlog.push_back(c);
		if (act <= ACT_LIST_BWD)
			planned++;
	endfunction

	initial begin
		int kind;
		int n;

		// directed: empty refusals, fill to the brim, refusal when full, walks, pops, unused codes
		add_cmd(ACT_LIST_FWD, $urandom);
		add_cmd(ACT_POP_FRONT, $urandom);
		add_cmd(ACT_POP_BACK, $urandom);
		add_cmd(ACT_LIST_BWD, $urandom);
		add_cmd(ACT_PUSH_FRONT, 32'h8000_0000);
		add_cmd(ACT_PUSH_BACK, 32'h7fff_ffff);
		add_cmd(ACT_PUSH_FRONT, 32'hffff_ffff);
		add_cmd(ACT_PUSH_BACK, 32'h0000_0000);
		for (int i = 0; i < DEPTH - 4; i++)
			add_cmd((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom);
		add_cmd(ACT_PUSH_FRONT, 32'h5a5a_a5a5);
		add_cmd(ACT_LIST_FWD, $urandom);
		add_cmd(ACT_LIST_BWD, $urandom);
		add_cmd(ACT_POP_FRONT, $urandom);
		add_cmd(ACT_POP_BACK, $urandom);
		add_cmd(ACT_W'(6), $urandom);
		add_cmd(ACT_W'(7), $urandom);

		// random bursts; fill and drain runs push the deque to both ends
		n = planned + RAND_CMDS;
		while (planned < n) begin
			kind = $urandom_range(0, 9);
			if (kind <= 2) begin
				repeat ($urandom_range(4, 20))
					add_cmd($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
						pick_value());
			end else if (kind <= 4) begin
				repeat ($urandom_range(4, 20))
					add_cmd($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
			end else if (kind == 5) begin
				add_cmd($urandom_range(0, 1) ? ACT_LIST_BWD : ACT_LIST_FWD, $urandom);
			end else begin
				repeat ($urandom_range(3, 10))
					add_cmd(ACT_W'($urandom_range(0, 5)), pick_value());
			end
			if ($urandom_range(0, 19) == 0)
				add_cmd(ACT_W'($urandom_range(6, 7)), $urandom);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() > 0 || s_tvalid || owed_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (owed_results.size() > 0)
			flag_mismatch($sformatf("%0d result beats never arrived", owed_results.size()));

		$display("covered %0d commands: %0d pushes, %0d pops, %0d walks, %0d unused codes",
			beats_in, n_push, n_pop, n_list, n_unused);
		$display("checked %0d result beats; %0d full and %0d empty refusals, peak fill %0d",
			beats_out, n_full, n_empty, max_held);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_dpath.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue_core.sv
sim/double_ended_queue_core_tb.sv
